// ----- sv/rcfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  localparam int unsigned ChWidth      = 11;
  localparam int unsigned FrameWidth   = 48;
  localparam int unsigned GainWidth    = 16;
  localparam int unsigned TargetWidth  = 32;
  localparam int unsigned TrimWidth    = 16;
  localparam int unsigned OutTdataWidth = 104;

  // register indexes on the config port
  localparam logic CfgPitchGain = 1'b0;
  localparam logic CfgYawGain   = 1'b1;

  localparam logic [GainWidth-1:0] PitchGainRst = 16'd197;
  localparam logic [GainWidth-1:0] YawGainRst   = 16'd187;

  // two-bit switch positions
  localparam logic [1:0] SwNone = 2'd0;
  localparam logic [1:0] SwUp   = 2'd1;
  localparam logic [1:0] SwDown = 2'd2;
  localparam logic [1:0] SwMid  = 2'd3;

  localparam logic [1:0] ModeOff   = 2'd0;
  localparam logic [1:0] ModeTest  = 2'd1;
  localparam logic [1:0] ModeReady = 2'd2;

  localparam logic signed [1:0] BrakeLeft   = -2'sd1;
  localparam logic signed [1:0] BrakeCentre = 2'sd0;
  localparam logic signed [1:0] BrakeRight  = 2'sd1;

  typedef struct packed {
    logic                          pc_off;
    logic                          feeder_on;
    logic                          friction_on;
    logic signed [1:0]             brake_dir;
    logic [1:0]                    remote_mode;
    logic signed [TrimWidth-1:0]   pitch_trim_halves;
    logic signed [TargetWidth-1:0] yaw_target;
    logic signed [TargetWidth-1:0] pitch_target;
    logic signed [ChWidth-1:0]     chassis_speed;
  } rcfd_result_t;

  // raw channel minus centre 1024: flipping the top bit gives the signed offset
  function automatic logic signed [ChWidth-1:0] ch_offset(input logic [ChWidth-1:0] raw);
    ch_offset = {~raw[ChWidth-1], raw[ChWidth-2:0]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/rcfd_sat_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcfd_sat_mac (
  input  wire logic signed [rcfd_pkg::TargetWidth-1:0] acc_i,
  input  wire logic signed [rcfd_pkg::ChWidth-1:0]     delta_i,
  input  wire logic        [rcfd_pkg::GainWidth-1:0]   gain_i,
  output      logic signed [rcfd_pkg::TargetWidth-1:0] acc_o
);
  import rcfd_pkg::*;

  localparam int unsigned ProdWidth = ChWidth + GainWidth + 1;
  localparam int unsigned SumWidth  = TargetWidth + 2;

  logic signed [ProdWidth-1:0] prod;
  logic signed [SumWidth-1:0]  sum;

  always_comb begin
    prod = ProdWidth'(delta_i) * ProdWidth'($signed({1'b0, gain_i}));
    sum  = SumWidth'(acc_i) + SumWidth'(prod);
    // top three bits disagree: out of 32-bit range
    if (sum[SumWidth-1] && !(sum[SumWidth-2] && sum[TargetWidth-1])) begin
      acc_o = {1'b1, {(TargetWidth-1){1'b0}}};
    end else if (!sum[SumWidth-1] && (sum[SumWidth-2] || sum[TargetWidth-1])) begin
      acc_o = {1'b0, {(TargetWidth-1){1'b1}}};
    end else begin
      acc_o = sum[TargetWidth-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- sv/rcfd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcfd_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic [rcfd_pkg::FrameWidth-1:0]    frame_i,
  input  wire logic [rcfd_pkg::GainWidth-1:0]     pitch_gain_i,
  input  wire logic [rcfd_pkg::GainWidth-1:0]     yaw_gain_i,
  output      rcfd_pkg::rcfd_result_t             result_o
);
  import rcfd_pkg::*;

  typedef enum logic [1:0] {
    ArmNone,
    ArmUp,
    ArmDown
  } arm_e;

  logic signed [ChWidth-1:0]     ch0, ch1, ch2, ch3;
  logic [1:0]                    s1, s2;
  logic signed [TargetWidth-1:0] pitch_sum, yaw_sum;

  arm_e                          arm_q, arm_d;
  logic signed [TrimWidth-1:0]   trim_q, trim_d;
  logic signed [TargetWidth-1:0] pitch_q, yaw_q;
  logic signed [ChWidth-1:0]     speed_q;
  logic [1:0]                    mode_q, mode_d;
  logic signed [1:0]             brake_q, brake_d;
  logic                          friction_q, friction_d;
  logic                          feeder_q, feeder_d;
  logic                          pc_off_q, pc_off_d;

  assign ch0 = ch_offset(frame_i[10:0]);
  assign ch1 = ch_offset(frame_i[21:11]);
  assign ch2 = ch_offset(frame_i[32:22]);
  assign ch3 = ch_offset(frame_i[43:33]);
  assign s2  = frame_i[45:44];
  assign s1  = frame_i[47:46];

  rcfd_sat_mac u_pitch_mac (
    .acc_i   (pitch_q),
    .delta_i (ch3),
    .gain_i  (pitch_gain_i),
    .acc_o   (pitch_sum)
  );

  rcfd_sat_mac u_yaw_mac (
    .acc_i   (yaw_q),
    .delta_i (ch2),
    .gain_i  (yaw_gain_i),
    .acc_o   (yaw_sum)
  );

  // trim counts on the return to centre after a push
  always_comb begin
    arm_d  = arm_q;
    trim_d = trim_q;
    if (ch0 != '0) begin
      arm_d = ch0[ChWidth-1] ? ArmDown : ArmUp;
    end else begin
      arm_d = ArmNone;
      if (arm_q == ArmUp && trim_q != {1'b0, {(TrimWidth-1){1'b1}}}) begin
        trim_d = trim_q + TrimWidth'(1);
      end else if (arm_q == ArmDown && trim_q != {1'b1, {(TrimWidth-1){1'b0}}}) begin
        trim_d = trim_q - TrimWidth'(1);
      end
    end
  end

  always_comb begin
    mode_d     = mode_q;
    brake_d    = brake_q;
    friction_d = friction_q;
    feeder_d   = feeder_q;
    pc_off_d   = pc_off_q;
    unique case (s2)
      SwUp: begin
        mode_d = ModeReady;
        unique case (s1)
          SwUp: begin
            friction_d = 1'b1;
            feeder_d   = 1'b1;
            brake_d    = BrakeRight;
          end
          SwDown: begin
            friction_d = 1'b0;
            feeder_d   = 1'b0;
            brake_d    = BrakeCentre;
          end
          SwMid: begin
            friction_d = 1'b1;
            feeder_d   = 1'b0;
            brake_d    = BrakeLeft;
          end
          default: ;
        endcase
      end
      SwMid: begin
        mode_d   = ModeTest;
        pc_off_d = (s1 == SwMid);
      end
      SwDown: begin
        mode_d  = ModeOff;
        brake_d = BrakeCentre;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q      <= ArmNone;
      trim_q     <= '0;
      pitch_q    <= '0;
      yaw_q      <= '0;
      speed_q    <= '0;
      mode_q     <= ModeOff;
      brake_q    <= BrakeCentre;
      friction_q <= 1'b0;
      feeder_q   <= 1'b0;
      pc_off_q   <= 1'b0;
    end else if (load_i) begin
      arm_q      <= arm_d;
      trim_q     <= trim_d;
      pitch_q    <= pitch_sum;
      yaw_q      <= yaw_sum;
      speed_q    <= ch1;
      mode_q     <= mode_d;
      brake_q    <= brake_d;
      friction_q <= friction_d;
      feeder_q   <= feeder_d;
      pc_off_q   <= pc_off_d;
    end
  end

  // state registers double as the result register
  always_comb begin
    result_o.chassis_speed     = speed_q;
    result_o.pitch_target      = pitch_q;
    result_o.yaw_target        = yaw_q;
    result_o.pitch_trim_halves = trim_q;
    result_o.remote_mode       = mode_q;
    result_o.brake_dir         = brake_q;
    result_o.friction_on       = friction_q;
    result_o.feeder_on         = feeder_q;
    result_o.pc_off            = pc_off_q;
  end

endmodule

`default_nettype wire

// ----- sv/rc_frame_decode_mode_logic.sv -----
// Remote-control frame decoder: stick channels, gain-scaled pitch/yaw targets, trim, mode flags.
// Frames pass the input register, then load the core state registers (the result register).
// Throughput: one frame per cycle unless the output stalls; each register holds one request.
// Reset (rst_ni low, async): targets, trim and flags clear, gains return to 197 and 187.
`timescale 1ns / 1ps
`default_nettype none

module rc_frame_decode_mode_logic (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  // rc_frame_bits
  input  wire logic [rcfd_pkg::FrameWidth-1:0]       s_axis_tdata,
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // chassis_speed, pitch_target, yaw_target, pitch_trim_halves, remote_mode,
  // brake_dir, friction_on, feeder_on, pc_off, zero pad
  output      logic [rcfd_pkg::OutTdataWidth-1:0]    m_axis_tdata,
  input  wire logic                                  cfg_valid_i,
  output      logic                                  cfg_ready_o,
  input  wire logic                                  cfg_index_i,
  input  wire logic [rcfd_pkg::GainWidth-1:0]        cfg_data_i
);
  import rcfd_pkg::*;

  localparam int unsigned ResWidth = $bits(rcfd_result_t);

  logic                  in_valid_q, in_valid_d;
  logic [FrameWidth-1:0] frame_q;
  logic                  out_valid_q, out_valid_d;
  logic                  advance;
  logic [GainWidth-1:0]  pitch_gain_q, yaw_gain_q;
  rcfd_result_t          result;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pitch_gain_q <= PitchGainRst;
      yaw_gain_q   <= YawGainRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgPitchGain: pitch_gain_q <= cfg_data_i;
          CfgYawGain:   yaw_gain_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      frame_q <= s_axis_tdata;
    end
  end

  rcfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .frame_i      (frame_q),
    .pitch_gain_i (pitch_gain_q),
    .yaw_gain_i   (yaw_gain_q),
    .result_o     (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataWidth-ResWidth){1'b0}}, result};

endmodule

`default_nettype wire
